@@ hdl/tcsu_pkg.sv @@
package tcsu_pkg;

    localparam logic [31:0] TAG_SIG  = 32'h5345_4335;
    localparam logic [31:0] TAG_END  = 32'h454E_4453;
    localparam logic [31:0] TAG_CODE = 32'h434F_4445;
    localparam logic [7:0]  KEY_ADD  = 8'h12;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_BAD_SIG = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_FILE = 2'd0,
        PH_HEAD = 2'd1,
        PH_DATA = 2'd2,
        PH_HALT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [31:0] tag;
        logic [15:0] index;
        logic        last;
    } result_t;

endpackage

@@ hdl/tagged_chunk_stream_unpacker_core.sv @@
// Channel   Handshake              Payload
// input     in_valid / in_stall    in_byte, start_of_file
// output    out_valid / out_stall  result_kind, out_byte, chunk_tag, chunk_index,
//                                  last_of_chunk
//
// One word per cycle while no stall holds: a word is held in the input register,
// the parser updates its state and fills the result register, and the result is
// offered from that register.
// Reset clears the parser state and both valid flags.
// A word that gives no result passes the parser even while the result register
// is stalled; a word with a result waits in the input register, and input
// stall rises once that register is held.
module tagged_chunk_stream_unpacker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic [31:0] chunk_tag,
    output logic [15:0] chunk_index,
    output logic        last_of_chunk
);
    import tcsu_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    fire;
    logic    emit;
    logic    out_free;
    result_t result;

    assign fire = item_valid && (!emit || out_free);

    tcsu_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .start_of_file (start_of_file),
        .fire          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    tcsu_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .emit   (emit),
        .result (result)
    );

    tcsu_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire && emit),
        .result        (result),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .out_byte      (out_byte),
        .chunk_tag     (chunk_tag),
        .chunk_index   (chunk_index),
        .last_of_chunk (last_of_chunk)
    );

endmodule

@@ hdl/tcsu_in_stage.sv @@
module tcsu_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           start_of_file,
    input  logic           fire,
    output logic           item_valid,
    output tcsu_pkg::item_t item
);
    import tcsu_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The held word leaves when the parser fires, so a new word may enter
    // in the same cycle.
    assign in_stall   = valid_reg && !fire;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.data <= in_byte;
            item_reg.sof  <= start_of_file;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/tcsu_parser.sv @@
module tcsu_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcsu_pkg::item_t   item,
    input  logic              fire,
    output logic              emit,
    output tcsu_pkg::result_t result
);
    import tcsu_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hbc_reg, hbc_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  key_reg, key_next;
    logic        dec_reg, dec_next;
    logic [15:0] done_reg, done_next;

    // Current state as seen by this word; a start-of-file word sees reset state.
    phase_t      ph;
    logic [2:0]  hbc;
    logic [31:0] tag;
    logic [31:0] size;
    logic [31:0] rem;
    logic [7:0]  key;
    logic        dec;
    logic [15:0] done;

    logic [31:0] tag_hdr;
    logic [31:0] size_hdr;
    logic [31:0] rem_dec;
    logic        last_hdr;
    logic        last_data;
    logic [15:0] done_inc;

    always_comb
    begin
        ph   = item.sof ? PH_FILE : phase_reg;
        hbc  = item.sof ? 3'd0 : hbc_reg;
        tag  = item.sof ? 32'd0 : tag_reg;
        size = item.sof ? 32'd0 : size_reg;
        rem  = item.sof ? 32'd0 : rem_reg;
        key  = item.sof ? 8'd0 : key_reg;
        dec  = item.sof ? 1'b0 : dec_reg;
        done = item.sof ? 16'd0 : done_reg;
    end

    assign tag_hdr   = hbc[2] ? tag : {tag[23:0], item.data};
    assign size_hdr  = hbc[2] ? {item.data, size[31:8]} : size;
    assign last_hdr  = (hbc == 3'd7);
    assign rem_dec   = rem - 32'd1;
    assign last_data = (rem_dec == 32'd0);
    assign done_inc  = (done != COUNT_MAX) ? done + 16'd1 : done;

    always_comb
    begin
        phase_next = ph;
        unique case (ph)
            PH_FILE:
            begin
                if (last_hdr)
                begin
                    phase_next = (tag_hdr != TAG_SIG) ? PH_HALT : PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                if (last_hdr && tag_hdr != TAG_END && size_hdr != 32'd0)
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (last_data)
                begin
                    phase_next = PH_HEAD;
                end
            end
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    always_comb
    begin
        hbc_next  = hbc;
        tag_next  = tag;
        size_next = size;
        rem_next  = rem;
        key_next  = key;
        dec_next  = dec;
        done_next = done;
        emit      = 1'b0;
        result    = '0;
        unique case (ph)
            PH_FILE:
            begin
                hbc_next  = hbc + 3'd1;
                tag_next  = tag_hdr;
                size_next = size_hdr;
                if (last_hdr && tag_hdr != TAG_SIG)
                begin
                    emit         = 1'b1;
                    result.kind  = KIND_BAD_SIG;
                    result.tag   = tag_hdr;
                    result.index = done;
                end
            end
            PH_HEAD:
            begin
                hbc_next  = hbc + 3'd1;
                tag_next  = tag_hdr;
                size_next = size_hdr;
                if (last_hdr && tag_hdr != TAG_END)
                begin
                    if (size_hdr == 32'd0)
                    begin
                        emit         = 1'b1;
                        result.kind  = KIND_EMPTY;
                        result.tag   = tag_hdr;
                        result.index = done;
                        result.last  = 1'b1;
                        done_next    = done_inc;
                    end
                    else
                    begin
                        rem_next = size_hdr;
                        key_next = 8'd0;
                        dec_next = (tag_hdr == TAG_CODE);
                    end
                end
            end
            PH_DATA:
            begin
                emit         = 1'b1;
                result.kind  = KIND_PAYLOAD;
                result.data  = dec ? (item.data ^ key) : item.data;
                result.tag   = tag;
                result.index = done;
                result.last  = last_data;
                key_next     = key + item.data + KEY_ADD;
                rem_next     = rem_dec;
                if (last_data)
                begin
                    done_next = done_inc;
                    hbc_next  = 3'd0;
                end
            end
            PH_HALT:
            begin
                emit = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FILE;
            hbc_reg   <= 3'd0;
            tag_reg   <= 32'd0;
            size_reg  <= 32'd0;
            rem_reg   <= 32'd0;
            key_reg   <= 8'd0;
            dec_reg   <= 1'b0;
            done_reg  <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hbc_reg   <= hbc_next;
            tag_reg   <= tag_next;
            size_reg  <= size_next;
            rem_reg   <= rem_next;
            key_reg   <= key_next;
            dec_reg   <= dec_next;
            done_reg  <= done_next;
        end
    end

endmodule

@@ hdl/tcsu_out_stage.sv @@
module tcsu_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tcsu_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        result_kind,
    output logic [7:0]        out_byte,
    output logic [31:0]       chunk_tag,
    output logic [15:0]       chunk_index,
    output logic              last_of_chunk
);
    import tcsu_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = valid_reg;
    assign result_kind   = result_reg.kind;
    assign out_byte      = result_reg.data;
    assign chunk_tag     = result_reg.tag;
    assign chunk_index   = result_reg.index;
    assign last_of_chunk = result_reg.last;

endmodule
